// ----- hdl/marker_delimited_archive_splitter_macros.svh -----
// ----------------------------------------------------------------------------
// marker_delimited_archive_splitter_macros
// assertion macros used by the archive splitter
// ----------------------------------------------------------------------------
`ifndef MARKER_DELIMITED_ARCHIVE_SPLITTER_MACROS_SVH
`define MARKER_DELIMITED_ARCHIVE_SPLITTER_MACROS_SVH

// same-cycle implication
`define MDAS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mdas assertion failed");

// next-cycle implication
`define MDAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mdas assertion failed");

`endif

// ----- hdl/mdas_pkg.sv -----
// ----------------------------------------------------------------------------
// mdas_pkg
// types and constants of the marker delimited archive splitter
// ----------------------------------------------------------------------------
package mdas_pkg;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_BODY = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END     = 2'd1,
        KIND_ARCHIVE = 2'd2
    } kind_t;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_START_MARKER = 2'd0;
    localparam cfg_index_t CFG_END_MARKER   = 2'd1;
    localparam cfg_index_t CFG_SEPARATOR    = 2'd2;
    localparam cfg_index_t CFG_MAX_FILE     = 2'd3;

    localparam int CFG_DATA_W = 32;
    localparam int MAX_FILE_W = 21;

    localparam logic [31:0]         START_MARKER_RST = 32'h7B2D215D;
    localparam logic [31:0]         END_MARKER_RST   = 32'h7B2B215D;
    localparam logic [23:0]         SEPARATOR_RST    = 24'h403E3C;
    localparam logic [MAX_FILE_W-1:0] MAX_FILE_RST   = 21'd20480;

    typedef struct packed {
        logic we;
        cfg_index_t index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

// ----- hdl/mdas_front.sv -----
// ----------------------------------------------------------------------------
// mdas_front
// marker hunt, separator scan and segment counting, one byte per cycle while in_fire is high
// ----------------------------------------------------------------------------
module mdas_front #(
    parameter int FILE_NUMBER_WIDTH = 16,
    parameter int LENGTH_WIDTH      = 21,
    parameter int RES_W             = 2 + 8 + FILE_NUMBER_WIDTH + LENGTH_WIDTH + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mdas_pkg::cfg_wr_t    cfg,
    input  logic                 in_fire,
    input  logic [7:0]           in_byte,
    output logic                 res_valid,
    output logic [RES_W-1:0]     res_data
);

    localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_WIDTH) - 33'd1;

    logic [31:0]                   start_reg;
    logic [31:0]                   end_reg;
    logic [23:0]                   sep_reg;
    logic [mdas_pkg::MAX_FILE_W-1:0] max_reg;

    mdas_pkg::phase_t              phase_reg, phase_next;
    logic [31:0]                   win_reg, win_next;
    logic [7:0]                    held_reg [3];
    logic [7:0]                    held_next [3];
    logic [1:0]                    held_cnt_reg, held_cnt_next;
    logic [1:0]                    skip_reg, skip_next;
    logic [FILE_NUMBER_WIDTH-1:0]  fc_reg, fc_next;
    logic [LENGTH_WIDTH-1:0]       seg_reg, seg_next;
    logic                          ovf_reg, ovf_next;

    mdas_pkg::kind_t               kind;
    logic [7:0]                    obyte;
    logic [32:0]                   lim;
    logic                          emit;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= mdas_pkg::START_MARKER_RST;
            end_reg   <= mdas_pkg::END_MARKER_RST;
            sep_reg   <= mdas_pkg::SEPARATOR_RST;
            max_reg   <= mdas_pkg::MAX_FILE_RST;
        end
        else if (cfg.we)
        begin
            case (cfg.index)
                mdas_pkg::CFG_START_MARKER: start_reg <= cfg.data;
                mdas_pkg::CFG_END_MARKER:   end_reg   <= cfg.data;
                mdas_pkg::CFG_SEPARATOR:    sep_reg   <= cfg.data[23:0];
                mdas_pkg::CFG_MAX_FILE:     max_reg   <= cfg.data[mdas_pkg::MAX_FILE_W-1:0];
                default:                    max_reg   <= max_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= mdas_pkg::PH_HUNT;
            win_reg      <= '0;
            held_cnt_reg <= '0;
            skip_reg     <= '0;
            fc_reg       <= FILE_NUMBER_WIDTH'(1);
            seg_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            win_reg      <= win_next;
            held_cnt_reg <= held_cnt_next;
            skip_reg     <= skip_next;
            fc_reg       <= fc_next;
            seg_reg      <= seg_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    always_comb
    begin
        phase_next    = phase_reg;
        win_next      = win_reg;
        held_next     = held_reg;
        held_cnt_next = held_cnt_reg;
        skip_next     = skip_reg;
        fc_next       = fc_reg;
        seg_next      = seg_reg;
        ovf_next      = ovf_reg;
        kind          = mdas_pkg::KIND_BYTE;
        obyte         = 8'd0;
        emit          = 1'b0;
        lim           = (33'(max_reg) > LEN_MAX) ? LEN_MAX : 33'(max_reg);

        if (in_fire)
        begin
            case (phase_reg)
                mdas_pkg::PH_HUNT:
                begin
                    win_next = {win_reg[23:0], in_byte};
                    if (held_cnt_reg == 2'd3 && win_next == start_reg)
                    begin
                        phase_next    = mdas_pkg::PH_BODY;
                        held_cnt_next = 2'd0;
                        skip_next     = 2'd0;
                    end
                    else if (held_cnt_reg != 2'd3)
                    begin
                        held_cnt_next = held_cnt_reg + 2'd1;
                    end
                end
                mdas_pkg::PH_BODY:
                begin
                    win_next = {win_reg[23:0], in_byte};
                    if (held_cnt_reg == 2'd3)
                    begin
                        if (win_next == end_reg)
                        begin
                            emit          = 1'b1;
                            kind          = mdas_pkg::KIND_ARCHIVE;
                            phase_next    = mdas_pkg::PH_DONE;
                            held_cnt_next = 2'd0;
                        end
                        else
                        begin
                            if (skip_reg != 2'd0)
                            begin
                                skip_next = skip_reg - 2'd1;
                            end
                            else if ({held_reg[0], held_reg[1], held_reg[2]} == sep_reg)
                            begin
                                emit      = 1'b1;
                                kind      = mdas_pkg::KIND_END;
                                fc_next   = fc_reg + FILE_NUMBER_WIDTH'(1);
                                seg_next  = '0;
                                ovf_next  = 1'b0;
                                skip_next = 2'd2;
                            end
                            else
                            begin
                                emit  = 1'b1;
                                kind  = mdas_pkg::KIND_BYTE;
                                obyte = held_reg[0];
                                if (33'(seg_reg) < lim)
                                begin
                                    seg_next = seg_reg + LENGTH_WIDTH'(1);
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            held_next[0] = held_reg[1];
                            held_next[1] = held_reg[2];
                            held_next[2] = in_byte;
                        end
                    end
                    else
                    begin
                        held_next[held_cnt_reg] = in_byte;
                        held_cnt_next           = held_cnt_reg + 2'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // end results report the state before the commit, byte results the updated count
    assign res_valid = emit;
    assign res_data  = (kind == mdas_pkg::KIND_BYTE)
                     ? {ovf_next, seg_next, fc_reg, obyte, kind}
                     : {ovf_reg, seg_reg, fc_reg, obyte, kind};

endmodule

// ----- hdl/mdas_queue.sv -----
// ----------------------------------------------------------------------------
// mdas_queue
// short result queue between the scanner and the output stage
// ----------------------------------------------------------------------------
module mdas_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + (PTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (PTR_W+1)'(1);
        end
    end

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem_reg[rd_ptr_reg];

endmodule

// ----- hdl/mdas_back.sv -----
// ----------------------------------------------------------------------------
// mdas_back
// output register, unpacks queued results onto the master stream
// ----------------------------------------------------------------------------
module mdas_back #(
    parameter int FILE_NUMBER_WIDTH = 16,
    parameter int LENGTH_WIDTH      = 21,
    parameter int RES_W             = 2 + 8 + FILE_NUMBER_WIDTH + LENGTH_WIDTH + 1,
    parameter int DATA_W            = ((8 + FILE_NUMBER_WIDTH + LENGTH_WIDTH + 1 + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_not_empty,
    input  logic [RES_W-1:0]  q_head,
    output logic              q_pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,
    output logic [1:0]        m_axis_tuser
);

    localparam int FIELD_W = RES_W - 2;

    logic               valid_reg, valid_next;
    logic [RES_W-1:0]   res_reg;

    assign q_pop      = q_not_empty && (!valid_reg || m_axis_tready);
    assign valid_next = q_pop || (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= q_head;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg[1:0];
    assign m_axis_tdata  = DATA_W'(res_reg[RES_W-1 -: FIELD_W]);

endmodule

// ----- hdl/marker_delimited_archive_splitter.sv -----
// ----------------------------------------------------------------------------
// marker_delimited_archive_splitter
// splits a marker delimited byte stream into file bytes and file commits
// ----------------------------------------------------------------------------
// s_axis takes one raw byte per transfer; m_axis gives one result per
// transfer, tuser is the kind (file byte, file end commit, archive end).
// bytes before the start marker are dropped; body bytes come out three input
// bytes late, once they are known not to start a separator or end marker.
// a file end commit carries the file length; the archive end result carries
// the trailing unterminated segment, which the consumer drops; later bytes
// are taken and ignored until reset.
// one byte per cycle while the queue is not full; the scanner updates its
// window and counters per byte; results pass the queue and output register.
// a four-entry result queue and the output register decouple the sides:
// when m_axis stalls, s_axis keeps taking bytes until the queue is full.
// reset restores the default markers, file number one and the hunt phase.
// cfg writes land on the clock edge where cfg_we is high.
// ----------------------------------------------------------------------------
`include "marker_delimited_archive_splitter_macros.svh"

module marker_delimited_archive_splitter #(
    parameter int FILE_NUMBER_WIDTH = 16,
    parameter int LENGTH_WIDTH      = 21
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte
    input  logic [7:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_byte, file_number, byte_count, overflow, zero pad
    output logic [((8 + FILE_NUMBER_WIDTH + LENGTH_WIDTH + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // kind
    output logic [1:0]  m_axis_tuser
);

    localparam int RES_W  = 2 + 8 + FILE_NUMBER_WIDTH + LENGTH_WIDTH + 1;
    localparam int DATA_W = ((8 + FILE_NUMBER_WIDTH + LENGTH_WIDTH + 1 + 7) / 8) * 8;

    mdas_pkg::cfg_wr_t cfg;
    logic              in_fire;
    logic              res_valid;
    logic [RES_W-1:0]  res_data;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic [RES_W-1:0]  q_head;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign s_axis_tready = !q_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    mdas_front #(
        .FILE_NUMBER_WIDTH (FILE_NUMBER_WIDTH),
        .LENGTH_WIDTH      (LENGTH_WIDTH),
        .RES_W             (RES_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_fire   (in_fire),
        .in_byte   (s_axis_tdata),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    mdas_queue #(
        .WIDTH (RES_W),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    mdas_back #(
        .FILE_NUMBER_WIDTH (FILE_NUMBER_WIDTH),
        .LENGTH_WIDTH      (LENGTH_WIDTH),
        .RES_W             (RES_W),
        .DATA_W            (DATA_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    `MDAS_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, res_valid, !q_full)
    `MDAS_ASSERT_IMPLY(a_end_results_no_byte, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser != mdas_pkg::KIND_BYTE), m_axis_tdata[7:0] == 8'd0)
    `MDAS_ASSERT_NEXT(a_archive_end_is_last, clk, rst_n,
        m_axis_tvalid && m_axis_tready && (m_axis_tuser == mdas_pkg::KIND_ARCHIVE),
        !m_axis_tvalid)

endmodule
